[design/sawsu_pkg.sv]
package sawsu_pkg;

  // Command codes on in_data.cmd
  localparam logic [1:0] CMD_SEND    = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_PERIOD = 2'd1;

  // Register reset values
  localparam logic [7:0]  WINDOW_SIZE_RST = 8'd8;
  localparam logic [6:0]  LOSS_PERIOD_RST = 7'd0;
  localparam logic [15:0] SEQ_RST         = 16'd1;

  typedef enum logic [3:0] {
    ACT_IGNORE      = 4'd0,
    ACT_TRANSMIT    = 4'd1,
    ACT_LOSS_DROP   = 4'd2,
    ACT_WINDOW_FULL = 4'd3,
    ACT_BASE_ADV    = 4'd4,
    ACT_ACK_CACHED  = 4'd5,
    ACT_RESEND      = 4'd6,
    ACT_NO_RESEND   = 4'd7,
    ACT_CACHE_FULL  = 4'd8
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DRAIN_RD,
    ST_DRAIN_CMP,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] ack_number;
    logic        checksum_ok;
    logic        fin_ack;
    logic        packet_is_fin;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] packet_seq;
    logic [15:0] window_base;
    logic [15:0] next_sequence;
    logic [7:0]  in_flight;
    logic        done_res;
  } out_item_t;

  // Control from the sequencer to the ack cache
  typedef struct packed {
    logic push;
    logic pop;
    logic rd;
  } cache_ctl_t;

  // Status from the ack cache
  typedef struct packed {
    logic        empty;
    logic        full;
    logic        one_left;
    logic [15:0] head_data;
  } cache_st_t;

  // Status of the remainder unit
  typedef struct packed {
    logic running;
    logic done;
    logic zero;
  } rem_st_t;

endpackage

[design/sawsu_rem.sv]
module sawsu_rem import sawsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output rem_st_t     stat
);

  logic [15:0] dvd_r, dvd_nxt;
  logic [7:0]  div_r, div_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [8:0]  trial;

  // One restoring step per cycle, MSB of the dividend first
  always_comb begin
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[15]};
    if (start) begin
      dvd_nxt = dividend;
      div_nxt = divisor;
      rem_nxt = '0;
      cnt_nxt = 4'd15;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = 8'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[7:0];
      end
      dvd_nxt = {dvd_r[14:0], 1'b0};
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.running = run_r;
  assign stat.done    = done_r;
  assign stat.zero    = (rem_r == 8'd0);

endmodule

[design/sawsu_cache.sv]
module sawsu_cache import sawsu_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cache_ctl_t  ctl,
  input  logic [15:0] wdata,
  output cache_st_t   stat
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [15:0]   mem [DEPTH];
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0]   rdata_r;
  logic [CW:0]   tail_sum;
  logic [CW:0]   tail_wrap;
  logic [AW-1:0] tail_idx;

  // Tail slot = (head + count) mod DEPTH, sum stays below twice the depth
  always_comb begin
    tail_sum  = (CW+1)'(head_r) + (CW+1)'(count_r);
    tail_wrap = (tail_sum >= (CW+1)'(DEPTH)) ? tail_sum - (CW+1)'(DEPTH) : tail_sum;
    tail_idx  = tail_wrap[AW-1:0];
  end

  // Head and fill count
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctl.pop) begin
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
      count_nxt = count_r - CW'(1);
    end else if (ctl.push) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Ack store: one write port, one registered read port at the head
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata_r <= mem[head_r];
    end
  end

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(DEPTH));
  assign stat.one_left  = (count_r == CW'(1));
  assign stat.head_data = rdata_r;

endmodule

[design/selective_ack_window_sender_unit.sv]
// Selective-repeat sender window. One command is taken when start is high
// and busy is low; exactly one result follows as a single-cycle out_valid
// strobe that the receiver must take on that cycle. Most commands go from
// idle through the reply state to the registered strobe. A send request with
// loss injection enabled waits on a one-bit-per-cycle remainder of the
// sequence number. An ack that advances the base drains cached acks from the
// ack store head, each entry examined in a read state, then a compare state.
// The ack store needs no clearing pass after reset.
module selective_ack_window_sender_unit import sawsu_pkg::*; #(
  parameter int unsigned ACK_CACHE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  state_t      state_r, state_nxt;
  logic [15:0] base_r, base_nxt;
  logic [15:0] next_r, next_nxt;
  logic        fin_sent_r, fin_sent_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  win_r;
  logic [6:0]  loss_r;
  act_t        act_r, act_nxt;
  logic [15:0] pseq_r, pseq_nxt;
  logic        isfin_r, isfin_nxt;
  out_item_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [15:0] outstanding;
  logic [15:0] ack_dist;
  logic        ack_ok;
  logic        rem_start;
  rem_st_t     rem_st;
  cache_ctl_t  cache_ctl;
  cache_st_t   cache_st;

  sawsu_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (next_r),
    .divisor  ({1'b0, loss_r} + 8'd1),
    .stat     (rem_st)
  );

  sawsu_cache #(
    .DEPTH (ACK_CACHE_DEPTH)
  ) u_cache (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cache_ctl),
    .wdata (in_data.ack_number),
    .stat  (cache_st)
  );

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Window arithmetic, mod 2^16
  assign outstanding = next_r - base_r;
  assign ack_dist    = in_data.ack_number - base_r;
  assign ack_ok      = in_data.checksum_ok && (ack_dist != 16'd0) &&
                       (ack_dist <= {8'd0, win_r}) && (ack_dist <= outstanding);

  // Sequencer: next state and state updates
  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    fin_sent_nxt  = fin_sent_r;
    done_nxt      = done_r;
    act_nxt       = act_r;
    pseq_nxt      = pseq_r;
    isfin_nxt     = isfin_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    rem_start     = 1'b0;
    cache_ctl     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt   = ACT_IGNORE;
          pseq_nxt  = '0;
          state_nxt = ST_REPLY;
          if (!done_r) begin
            unique case (in_data.cmd)
              CMD_SEND: begin
                if (!fin_sent_r) begin
                  if (outstanding >= {8'd0, win_r}) begin
                    act_nxt = ACT_WINDOW_FULL;
                  end else if (loss_r != 7'd0) begin
                    isfin_nxt = in_data.packet_is_fin;
                    rem_start = 1'b1;
                    state_nxt = ST_DIV;
                  end else begin
                    act_nxt      = ACT_TRANSMIT;
                    pseq_nxt     = next_r;
                    next_nxt     = next_r + 16'd1;
                    fin_sent_nxt = fin_sent_r | in_data.packet_is_fin;
                  end
                end
              end
              CMD_ACK: begin
                if (ack_ok) begin
                  if (in_data.fin_ack) begin
                    done_nxt = 1'b1;
                  end
                  if (ack_dist == 16'd1) begin
                    act_nxt  = ACT_BASE_ADV;
                    base_nxt = base_r + 16'd1;
                    if (!cache_st.empty) begin
                      state_nxt = ST_DRAIN_RD;
                    end
                  end else if (cache_st.full) begin
                    act_nxt = ACT_CACHE_FULL;
                  end else begin
                    cache_ctl.push = 1'b1;
                    act_nxt        = ACT_ACK_CACHED;
                  end
                end
              end
              CMD_TIMEOUT: begin
                if (outstanding == 16'd0) begin
                  act_nxt = ACT_NO_RESEND;
                end else begin
                  act_nxt  = ACT_RESEND;
                  pseq_nxt = base_r;
                end
              end
              default: begin
                act_nxt = ACT_IGNORE;
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        // Drop when the sequence number is a multiple of period+1
        if (rem_st.done) begin
          act_nxt      = rem_st.zero ? ACT_LOSS_DROP : ACT_TRANSMIT;
          pseq_nxt     = next_r;
          next_nxt     = next_r + 16'd1;
          fin_sent_nxt = fin_sent_r | isfin_r;
          state_nxt    = ST_REPLY;
        end
      end
      ST_DRAIN_RD: begin
        cache_ctl.rd = 1'b1;
        state_nxt    = ST_DRAIN_CMP;
      end
      ST_DRAIN_CMP: begin
        // Only the head is checked; a mismatch blocks the rest
        if (cache_st.head_data == base_r + 16'd1) begin
          cache_ctl.pop = 1'b1;
          base_nxt      = base_r + 16'd1;
          state_nxt     = cache_st.one_left ? ST_REPLY : ST_DRAIN_RD;
        end else begin
          state_nxt = ST_REPLY;
        end
      end
      ST_REPLY: begin
        out_nxt.action        = act_r;
        out_nxt.packet_seq    = pseq_r;
        out_nxt.window_base   = base_r;
        out_nxt.next_sequence = next_r;
        out_nxt.in_flight     = outstanding[7:0];
        out_nxt.done_res      = done_r;
        out_valid_nxt         = 1'b1;
        state_nxt             = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= SEQ_RST;
      next_r      <= SEQ_RST;
      fin_sent_r  <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      fin_sent_r  <= fin_sent_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers, written on a cfg transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= WINDOW_SIZE_RST;
      loss_r <= LOSS_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WINDOW_SIZE) begin
        win_r <= cfg_data;
      end else if (cfg_index == CFG_LOSS_PERIOD) begin
        loss_r <= cfg_data[6:0];
      end
    end
  end

  // Per-item payload
  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    pseq_r  <= pseq_nxt;
    isfin_r <= isfin_nxt;
    out_r   <= out_nxt;
  end

  // A result strobe always follows the reply state
  a_strobe_after_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_REPLY))
    else $error("result strobe without reply state");

  // The remainder unit only runs while the sequencer waits on it
  a_rem_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_st.running |-> (state_r == ST_DIV))
    else $error("remainder unit running outside division wait");

  // A drain never pops an empty cache
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cache_ctl.pop |-> !cache_st.empty)
    else $error("ack cache popped while empty");

  // Push and drain belong to different commands
  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(cache_ctl.push && (cache_ctl.pop || cache_ctl.rd)))
    else $error("ack cache push overlaps drain");

endmodule

[test/selective_ack_window_sender_unit_tb.sv]
module selective_ack_window_sender_unit_tb;
  import sawsu_pkg::*;

  localparam int unsigned CACHE_DEPTH   = 256;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam int          LIMIT_TIME    = 5_000_000;
  localparam int          TB_FIFO_DEPTH = 8192;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_data = '0;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  selective_ack_window_sender_unit #(
    .ACK_CACHE_DEPTH(CACHE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Window model state, mirrors the block after reset
  logic [7:0]  win_sz = WINDOW_SIZE_RST;
  logic [6:0]  loss_per = LOSS_PERIOD_RST;
  logic [15:0] base_q = SEQ_RST;
  logic [15:0] next_q = SEQ_RST;
  logic [15:0] ack_cache [0:CACHE_DEPTH-1];
  logic [7:0]  cache_head = '0;
  logic [8:0]  cache_cnt = '0;
  bit          fin_sent = 1'b0;
  bit          session_done = 1'b0;

  // Pending commands and predicted results, kept as ring buffers
  in_item_t    pending_cmds [TB_FIFO_DEPTH];
  logic [12:0] pend_wr = '0;
  logic [12:0] pend_rd = '0;
  out_item_t   due_results [TB_FIFO_DEPTH];
  logic [12:0] due_wr = '0;
  logic [12:0] due_rd = '0;

  bit          gaps_on = 1'b1;
  int          gap_left = 0;
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned seen_by_action [0:15];
  out_item_t   oldest_due;

  // Advance the window model by one command and return the result it yields
  function automatic out_item_t sender_step(in_item_t it);
    out_item_t   r;
    act_t        act;
    logic [15:0] inflight;
    logic [15:0] ack_gap;
    logic [7:0]  tail_idx;
    r = '0;
    act = ACT_IGNORE;
    inflight = next_q - base_q;
    if (!session_done) begin
      case (it.cmd)
        CMD_SEND: begin
          if (!fin_sent) begin
            if (inflight >= {8'd0, win_sz}) begin
              act = ACT_WINDOW_FULL;
            end else begin
              r.packet_seq = next_q;
              if (loss_per != 0 && (int'(next_q) % (int'(loss_per) + 1)) == 0)
                act = ACT_LOSS_DROP;
              else
                act = ACT_TRANSMIT;
              next_q = next_q + 16'd1;
              if (it.packet_is_fin) fin_sent = 1'b1;
            end
          end
        end
        CMD_ACK: begin
          ack_gap = it.ack_number - base_q;
          if (it.checksum_ok && ack_gap >= 16'd1 && ack_gap <= {8'd0, win_sz} &&
              ack_gap <= inflight) begin
            if (ack_gap == 16'd1) begin
              act = ACT_BASE_ADV;
              base_q = base_q + 16'd1;
              // walk the cache head while it continues the run
              while (cache_cnt != 0 && ack_cache[cache_head] == base_q + 16'd1) begin
                cache_head = cache_head + 8'd1;
                cache_cnt = cache_cnt - 9'd1;
                base_q = base_q + 16'd1;
              end
            end else if (cache_cnt >= CACHE_DEPTH) begin
              act = ACT_CACHE_FULL;
            end else begin
              tail_idx = cache_head + cache_cnt[7:0];
              ack_cache[tail_idx] = it.ack_number;
              cache_cnt = cache_cnt + 9'd1;
              act = ACT_ACK_CACHED;
            end
            if (it.fin_ack) session_done = 1'b1;
          end
        end
        CMD_TIMEOUT: begin
          if (inflight == 0) begin
            act = ACT_NO_RESEND;
          end else begin
            act = ACT_RESEND;
            r.packet_seq = base_q;
          end
        end
        default: act = ACT_IGNORE;
      endcase
    end
    r.action = act;
    r.window_base = base_q;
    r.next_sequence = next_q;
    r.in_flight = 8'(next_q - base_q);
    r.done_res = session_done;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  function automatic int unsigned min2(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // Command driver: one transfer per start/!busy edge, random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        due_results[due_wr] = sender_step(in_data);
        due_wr = due_wr + 13'd1;
        n_accepted++;
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pend_wr != pend_rd) begin
          if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap_left <= int'($urandom_range(0, 8));
            start <= 1'b0;
          end else begin
            start <= 1'b1;
            in_data <= pending_cmds[pend_rd];
            pend_rd = pend_rd + 13'd1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each strobe is compared with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_results++;
      seen_by_action[out_data.action]++;
      if (due_wr == due_rd) begin
        $error("unexpected result: action %0d seq %0d", out_data.action,
               out_data.packet_seq);
        mismatch_cnt++;
      end else begin
        oldest_due = due_results[due_rd];
        due_rd = due_rd + 13'd1;
        check_field("action", 32'(oldest_due.action), 32'(out_data.action));
        check_field("packet_seq", 32'(oldest_due.packet_seq), 32'(out_data.packet_seq));
        check_field("window_base", 32'(oldest_due.window_base),
                    32'(out_data.window_base));
        check_field("next_sequence", 32'(oldest_due.next_sequence),
                    32'(out_data.next_sequence));
        check_field("in_flight", 32'(oldest_due.in_flight), 32'(out_data.in_flight));
        check_field("done_res", 32'(oldest_due.done_res), 32'(out_data.done_res));
      end
    end
  end

  function automatic in_item_t mk_cmd(logic [1:0] cmd, logic [15:0] ackn, logic csum,
                                      logic fa, logic pf);
    in_item_t it;
    it.cmd = cmd;
    it.ack_number = ackn;
    it.checksum_ok = csum;
    it.fin_ack = fa;
    it.packet_is_fin = pf;
    return it;
  endfunction

  task automatic add_cmd(in_item_t it);
    pending_cmds[pend_wr] = it;
    pend_wr = pend_wr + 13'd1;
    n_queued++;
  endtask

  task automatic add_send(logic pf);
    add_cmd(mk_cmd(CMD_SEND, 16'($urandom), 1'($urandom), 1'($urandom), pf));
  endtask

  task automatic add_ack(logic [15:0] num, logic csum, logic fa);
    add_cmd(mk_cmd(CMD_ACK, num, csum, fa, 1'($urandom)));
  endtask

  task automatic add_timeout();
    add_cmd(mk_cmd(CMD_TIMEOUT, 16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
  endtask

  // Commands that must leave the window untouched (timeouts aside)
  task automatic add_noise();
    case ($urandom_range(0, 4))
      0: add_cmd(mk_cmd(CMD_UNUSED, 16'($urandom), 1'($urandom), 1'($urandom),
                        1'($urandom)));
      1: add_ack(16'($urandom), 1'b0, 1'($urandom));
      // far outside any window even after this round's advances
      2: add_ack(base_q + 16'h8000 + 16'($urandom_range(0, 16'h3fff)), 1'b1,
                 1'($urandom));
      default: add_timeout();
    endcase
  endtask

  // Wait until every queued command has produced its result
  task automatic wait_idle();
    do @(posedge clk);
    while (n_results < n_queued);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    repeat ($urandom_range(0, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_WINDOW_SIZE: win_sz = val;
      CFG_LOSS_PERIOD: loss_per = val[6:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // One burst of sends followed by acks in orders that never strand the cache:
  // plain in-order runs, or a run cached ascending and then released by its first
  task automatic traffic_round();
    logic [15:0] span;
    logic [15:0] b;
    int unsigned inflight, room, n_send, sent, to_ack, acked, k;
    span = next_q - base_q;
    inflight = 32'(span);
    room = (inflight < 32'(win_sz)) ? 32'(win_sz) - inflight : 32'd0;
    if ($urandom_range(0, 3) == 0)
      add_ack(next_q + 16'd1 + 16'($urandom_range(0, 3)), 1'b1, 1'b0);
    n_send = $urandom_range(0, min2(room, 40));
    if (room == 0 || $urandom_range(0, 3) == 0) n_send += $urandom_range(1, 2);
    for (int i = 0; i < n_send; i++) begin
      add_send(1'b0);
      if ($urandom_range(0, 7) == 0) add_noise();
    end
    sent = min2(n_send, room);
    inflight += sent;
    to_ack = ($urandom_range(0, 3) == 0) ? $urandom_range(0, inflight) : inflight;
    b = base_q;
    acked = 0;
    while (acked < to_ack) begin
      k = $urandom_range(1, min2(min2(32'(win_sz), to_ack - acked), 8));
      if (k > 1 && $urandom_range(0, 1) == 1) begin
        for (int j = 2; j <= k; j++) add_ack(b + 16'(j), 1'b1, 1'b0);
        add_ack(b + 16'd1, 1'b1, 1'b0);
      end else begin
        for (int j = 1; j <= k; j++) add_ack(b + 16'(j), 1'b1, 1'b0);
      end
      b = b + 16'(k);
      acked += k;
      if ($urandom_range(0, 2) == 0) add_noise();
    end
  endtask

  initial begin
    logic [15:0] b;
    logic [15:0] span;
    int unsigned target;
    for (int i = 0; i < 16; i++) seen_by_action[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening at reset settings (window 8, no loss)
    add_timeout();                        // nothing in flight
    add_cmd(mk_cmd(CMD_UNUSED, 16'hffff, 1'b1, 1'b1, 1'b1));
    add_ack(16'd1, 1'b1, 1'b0);           // ack at the base itself
    for (int i = 0; i < 9; i++) add_send(1'b0);  // last one hits a full window
    add_timeout();                        // resend of base
    add_ack(16'd3, 1'b0, 1'b1);           // bad checksum
    add_ack(16'hffff, 1'b1, 1'b1);        // below the window
    add_ack(16'd3, 1'b1, 1'b0);
    add_ack(16'd4, 1'b1, 1'b0);
    add_ack(16'd2, 1'b1, 1'b0);           // advance and drain two cached acks
    add_ack(16'd6, 1'b1, 1'b0);
    add_ack(16'd5, 1'b1, 1'b0);
    add_ack(16'd10, 1'b1, 1'b0);          // packet not yet sent
    wait_idle();

    // Random traffic over a spread of register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_WINDOW_SIZE, 8'd1); write_reg(CFG_LOSS_PERIOD, 8'd1); end
        1: begin write_reg(CFG_WINDOW_SIZE, 8'd255); write_reg(CFG_LOSS_PERIOD, 8'd100); end
        2: begin write_reg(CFG_WINDOW_SIZE, 8'd3); write_reg(CFG_LOSS_PERIOD, 8'd2); end
        3: begin
          write_reg(CFG_WINDOW_SIZE, 8'($urandom_range(1, 255)));
          write_reg(CFG_LOSS_PERIOD, 8'($urandom_range(0, 100)));
        end
        4: begin
          write_reg(CFG_LOSS_PERIOD, 8'($urandom_range(3, 20)));
          write_reg(CFG_WINDOW_SIZE, 8'($urandom_range(2, 16)));
        end
        default: begin write_reg(CFG_WINDOW_SIZE, 8'd255); write_reg(CFG_LOSS_PERIOD, 8'd0); end
      endcase
      target = n_queued + 100;
      while (n_queued < target) begin
        traffic_round();
        wait_idle();
      end
    end

    // Closing stretch, back to back: head blocking, cache overflow, session end
    gaps_on = 1'b0;
    write_reg(CFG_WINDOW_SIZE, 8'd8);
    write_reg(CFG_LOSS_PERIOD, 8'd0);
    span = next_q - base_q;
    for (int i = int'(span); i < 3; i++) add_send(1'b0);
    wait_idle();
    b = base_q;
    add_ack(b + 16'd3, 1'b1, 1'b0);
    add_ack(b + 16'd2, 1'b1, 1'b0);
    add_ack(b + 16'd1, 1'b1, 1'b0);       // head does not continue the run
    for (int i = 0; i < CACHE_DEPTH + 2; i++) add_ack(b + 16'd3, 1'b1, 1'b0);
    add_ack(b + 16'd2, 1'b1, 1'b0);
    wait_idle();

    b = base_q;
    span = next_q - base_q;
    for (int j = 1; j <= span; j++) add_ack(b + 16'(j), 1'b1, 1'b0);
    add_send(1'b1);                       // FIN packet
    add_send(1'b1);                       // refused after FIN
    add_timeout();
    add_ack(b + span + 16'd1, 1'b1, 1'b1); // FIN+ACK
    add_send(1'b0);
    add_timeout();
    add_ack(b + span + 16'd2, 1'b1, 1'b0);
    wait_idle();
    repeat (20) @(posedge clk);

    $display("run: %0d commands in, %0d results checked, %0d mismatches",
             n_accepted, n_results, mismatch_cnt);
    $display("run: loss drops %0d, window full %0d, cached %0d, cache full %0d, resends %0d",
             seen_by_action[ACT_LOSS_DROP], seen_by_action[ACT_WINDOW_FULL],
             seen_by_action[ACT_ACK_CACHED], seen_by_action[ACT_CACHE_FULL],
             seen_by_action[ACT_RESEND]);
    if (mismatch_cnt == 0 && due_wr == due_rd)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_TIME);
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
design/sawsu_pkg.sv
design/sawsu_rem.sv
design/sawsu_cache.sv
design/selective_ack_window_sender_unit.sv
test/selective_ack_window_sender_unit_tb.sv
